/* sv/sha_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW = $clog2(FifoDepth);

	typedef struct packed {
		logic        last;
		logic [31:0] word;
	} word_beat_t;

	typedef enum logic {
		FRONT_ACCEPT,
		FRONT_PAD
	} front_state_t;

	typedef enum logic [1:0] {
		CORE_RUN,
		CORE_ADD,
		CORE_EMIT
	} core_state_t;

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [3:0] LenHiPos = 4'd14;
	localparam logic [3:0] LenLoPos = 4'd15;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
		ror = (x >> s) | (x << (32 - s));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction
endpackage

/* sv/sha_front.sv */
// Front end: accepts byte beats, packs big-endian words, generates padding and length.
module sha_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	input  logic                s_tlast,
	input  logic                q_full,
	output logic                q_push,
	output sha_pkg::word_beat_t q_wdata
);
	import sha_pkg::*;

	front_state_t state_q, state_d;
	logic [23:0]  acc_q;
	logic [60:0]  cnt_q;
	logic [3:0]   pos_q;
	logic         first_q;
	logic         lenok_q;
	logic         beat;
	logic [63:0]  bit_len;
	logic [31:0]  pad_word;

	assign beat = s_tvalid && s_tready;
	assign bit_len = {cnt_q, 3'b000};

	always_comb begin
		case (cnt_q[1:0])
			2'd0: pad_word = {PadMark, 24'h0};
			2'd1: pad_word = {acc_q[7:0], PadMark, 16'h0};
			2'd2: pad_word = {acc_q[15:0], PadMark, 8'h0};
			default: pad_word = {acc_q[23:0], PadMark};
		endcase
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		q_push = 1'b0;
		q_wdata = '0;
		case (state_q)
			FRONT_ACCEPT: begin
				s_tready = !q_full;
				if (beat) begin
					if (s_tuser && cnt_q[1:0] == 2'd3) begin
						q_push = 1'b1;
						q_wdata.word = {acc_q, s_tdata};
					end
					if (s_tlast)
						state_d = FRONT_PAD;
				end
			end
			FRONT_PAD: begin
				if (!q_full) begin
					q_push = 1'b1;
					if (first_q)
						q_wdata.word = pad_word;
					else if (lenok_q && pos_q == LenHiPos)
						q_wdata.word = bit_len[63:32];
					else if (lenok_q && pos_q == LenLoPos) begin
						q_wdata.word = bit_len[31:0];
						q_wdata.last = 1'b1;
						state_d = FRONT_ACCEPT;
					end
				end
			end
			default: state_d = FRONT_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRONT_ACCEPT;
			acc_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			first_q <= 1'b0;
			lenok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_push)
				pos_q <= pos_q + 4'd1;
			if (state_q == FRONT_ACCEPT && beat) begin
				if (s_tuser) begin
					acc_q <= {acc_q[15:0], s_tdata};
					cnt_q <= cnt_q + 61'd1;
				end
				first_q <= 1'b1;
				lenok_q <= 1'b0;
			end
			if (state_q == FRONT_PAD && q_push) begin
				first_q <= 1'b0;
				if (first_q)
					lenok_q <= (pos_q != LenHiPos);
				else if (pos_q == LenLoPos)
					lenok_q <= 1'b1;
				if (q_wdata.last) begin
					acc_q <= '0;
					cnt_q <= '0;
					pos_q <= '0;
					lenok_q <= 1'b0;
				end
			end
		end
	end
endmodule

/* sv/sha_fifo.sv */
// Short word queue between the front end and the compression core.
module sha_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sha_pkg::word_beat_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                rvalid,
	output sha_pkg::word_beat_t rdata
);
	import sha_pkg::*;

	word_beat_t           mem [FifoDepth];
	logic [FifoPtrW-1:0]  wr_q;
	logic [FifoPtrW-1:0]  rd_q;
	logic [FifoPtrW:0]    cnt_q;

	assign full = (cnt_q == (FifoPtrW+1)'(FifoDepth));
	assign rvalid = (cnt_q != '0);
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

/* sv/sha_core.sv */
// Compression core: one round per cycle while message words are available, hash update, digest output register.
module sha_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  sha_pkg::word_beat_t q_rdata,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);
	import sha_pkg::*;

	core_state_t  state_q, state_d;
	logic [5:0]   t_q;
	logic [31:0]  v_q [8];
	logic [31:0]  h_q [8];
	logic [31:0]  w_q [16];
	logic [63:0]  dig_q [4];
	logic [1:0]   idx_q;
	logic         last_q;
	logic         step;
	logic [31:0]  w_t, t1, t2, ch, maj;

	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign w_t = (t_q < 6'd16) ? q_rdata.word :
		ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ch + RoundK[t_q] + w_t;
	assign t2 = bsig0(v_q[0]) + maj;

	assign m_tvalid = (state_q == CORE_EMIT);
	assign m_tdata = dig_q[idx_q];
	assign m_tuser = idx_q;
	assign m_tlast = (idx_q == 2'd3);

	always_comb begin
		state_d = state_q;
		step = 1'b0;
		q_pop = 1'b0;
		case (state_q)
			CORE_RUN: begin
				step = (t_q >= 6'd16) || q_valid;
				q_pop = (t_q < 6'd16) && q_valid;
				if (step && t_q == 6'd63)
					state_d = CORE_ADD;
			end
			CORE_ADD: state_d = last_q ? CORE_EMIT : CORE_RUN;
			CORE_EMIT: begin
				if (m_tready && idx_q == 2'd3)
					state_d = CORE_RUN;
			end
			default: state_d = CORE_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_RUN;
			t_q <= '0;
			idx_q <= '0;
			last_q <= 1'b0;
			v_q <= InitHash;
			h_q <= InitHash;
		end else begin
			state_q <= state_d;
			if (step) begin
				t_q <= t_q + 6'd1;
				if (t_q == 6'd15)
					last_q <= q_rdata.last;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (state_q == CORE_ADD) begin
				for (int i = 0; i < 8; i++) begin
					if (last_q) begin
						h_q[i] <= InitHash[i];
						v_q[i] <= InitHash[i];
					end else begin
						h_q[i] <= h_q[i] + v_q[i];
						v_q[i] <= h_q[i] + v_q[i];
					end
				end
			end
			if (state_q == CORE_EMIT && m_tready)
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_t;
		end
		if (state_q == CORE_ADD) begin
			for (int k = 0; k < 4; k++)
				dig_q[k] <= {h_q[2*k] + v_q[2*k], h_q[2*k+1] + v_q[2*k+1]};
		end
	end
endmodule

/* sv/sha256_hash_stream.sv */
// Top level of the SHA-256 byte stream hasher.
// Takes one message byte per beat (tuser = byte present, tlast = end of message) and after
// the end beat returns the 256-bit digest as four 64-bit beats, most significant first.
// A front end packs bytes into words and appends padding and the bit length; a four-entry
// word queue feeds the compression core, which runs one round per cycle while it has the
// message words it needs; each 64-byte block takes 64 rounds plus the hash add. The front
// end takes one byte per cycle while the queue has room and it is not padding, but the
// core only takes words during its first 16 rounds, so once the queue fills, bytes wait
// until the core starts the next block.
// Finishing a message adds one or two padded blocks plus four output beats.
module sha256_hash_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [63:0] digest_word
	output logic [1:0]  m_tuser,  // [1:0] word_index
	output logic        m_tlast
);
	import sha_pkg::*;

	word_beat_t push_data;
	word_beat_t pop_data;
	logic       push, pop, full, pop_valid;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.q_full(full), .q_push(push), .q_wdata(push_data)
	);

	sha_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(push_data), .full(full),
		.pop(pop), .rvalid(pop_valid), .rdata(pop_data)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.q_valid(pop_valid), .q_rdata(pop_data), .q_pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);
endmodule
